/* hdl/gsd_pkg.sv */
`timescale 1ns / 1ps

package gsd_pkg;

  // Field widths fixed by the sample and result formats
  localparam int RATE_W       = 20;
  localparam int NUM_AXES     = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_LEN_W    = 13;
  localparam int CFG_THR_W    = 16;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATE_ENABLE = 2'd2;

  // Register reset values
  localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RST    = 13'd1000;
  localparam logic [CFG_THR_W-1:0] SPAN_THRESHOLD_RST   = 16'd0;
  localparam logic                 CALIBRATE_ENABLE_RST = 1'b1;

  // Per-axis span margins in whole deg/s (x, y, z)
  localparam int MARGIN_W = 3;
  localparam logic [MARGIN_W-1:0] AXIS_MARGIN [NUM_AXES] = '{3'd2, 3'd4, 3'd5};

  // Bias saturation limit
  localparam logic [RATE_W-1:0] RATE_MAX = 20'h7FFFF;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
  } gsd_in_t;

  typedef struct packed {
    logic                     is_quiet;
    logic                     offsets_valid;
    logic signed [RATE_W-1:0] bias_x;
    logic signed [RATE_W-1:0] bias_y;
    logic signed [RATE_W-1:0] bias_z;
  } gsd_out_t;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] window_length;
    logic [CFG_THR_W-1:0] span_threshold;
    logic                 calibrate_enable;
  } gsd_cfg_t;

  // Classification of a closed window, passed from front to back
  typedef struct packed {
    logic is_quiet;
    logic offsets_valid;
  } gsd_flags_t;

endpackage

/* hdl/gsd_job_queue.sv */
`timescale 1ns / 1ps

module gsd_job_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [FW-1:0]    fill_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill_r == FW'(DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // Hold stored items
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue overflow");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job queue underflow");

endmodule

/* hdl/gsd_front.sv */
`timescale 1ns / 1ps

module gsd_front #(
  parameter int MAX_WINDOW = 4096,
  parameter int FRAC_BITS  = 8,
  parameter int SW         = 32,
  parameter int CW         = 13
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gsd_pkg::gsd_cfg_t        cfg,
  input  logic                     in_push,
  input  gsd_pkg::gsd_in_t         in_item,
  output logic                     in_full,
  output logic                     job_push,
  input  logic                     job_full,
  output gsd_pkg::gsd_flags_t      job_flags,
  output logic signed [SW-1:0]     job_sum [gsd_pkg::NUM_AXES],
  output logic [CW-1:0]            job_count
);

  import gsd_pkg::*;

  localparam int LW   = (CW > CFG_LEN_W) ? CW : CFG_LEN_W;
  localparam int MW   = ((FRAC_BITS + MARGIN_W) > CFG_THR_W) ? (FRAC_BITS + MARGIN_W) : CFG_THR_W;
  localparam int CMPW = ((MW + 1) > (RATE_W + 1)) ? (MW + 1) : (RATE_W + 1);

  logic [CW-1:0]               count_r;
  logic                        close_r;
  logic signed [RATE_W-1:0]    high_r [NUM_AXES];
  logic signed [RATE_W-1:0]    low_r  [NUM_AXES];
  logic signed [SW-1:0]        sum_r  [NUM_AXES];

  logic signed [RATE_W-1:0]    rate     [NUM_AXES];
  logic signed [RATE_W-1:0]    high_nxt [NUM_AXES];
  logic signed [RATE_W-1:0]    low_nxt  [NUM_AXES];
  logic signed [SW-1:0]        sum_nxt  [NUM_AXES];
  logic [CW-1:0]               count_nxt;
  logic                        close_nxt;
  logic [LW-1:0]               len_req;
  logic [LW-1:0]               len_eff;
  logic                        accept;
  logic                        seed;
  logic [NUM_AXES-1:0]         axis_quiet;

  assign rate[0] = in_item.rate_x;
  assign rate[1] = in_item.rate_y;
  assign rate[2] = in_item.rate_z;

  // Stall while a closed window is handed on or the job queue is full
  assign in_full = close_r | job_full;
  assign accept  = in_push & ~in_full;
  assign seed    = (count_r == '0);

  // Clamp the window length to 1..MAX_WINDOW
  assign len_req = LW'(cfg.window_length);
  always_comb begin
    if (len_req == '0) begin
      len_eff = LW'(1);
    end else if (len_req > LW'(MAX_WINDOW)) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = len_req;
    end
  end

  assign count_nxt = count_r + 1'b1;
  assign close_nxt = (LW'(count_nxt) >= len_eff);

  // Track per-axis peaks and sum
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      high_nxt[a] = (seed || rate[a] > high_r[a]) ? rate[a] : high_r[a];
      low_nxt[a]  = (seed || rate[a] < low_r[a])  ? rate[a] : low_r[a];
      sum_nxt[a]  = (seed ? '0 : sum_r[a])
                  + signed'({{(SW - RATE_W){rate[a][RATE_W-1]}}, rate[a]});
    end
  end

  // Compare each span with threshold plus margin
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic signed [RATE_W:0] span;
      logic [CMPW-1:0]        limit;
      span  = {high_r[a][RATE_W-1], high_r[a]} - {low_r[a][RATE_W-1], low_r[a]};
      limit = CMPW'(cfg.span_threshold) + (CMPW'(AXIS_MARGIN[a]) << FRAC_BITS);
      axis_quiet[a] = (CMPW'($unsigned(span)) < limit);
    end
  end

  assign job_push                = close_r;
  assign job_flags.is_quiet      = &axis_quiet;
  assign job_flags.offsets_valid = (&axis_quiet) & cfg.calibrate_enable;
  assign job_sum                 = sum_r;
  assign job_count               = count_r;

  // Advance the sample count, mark the closing sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      close_r <= 1'b0;
    end else if (close_r) begin
      count_r <= '0;
      close_r <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      close_r <= close_nxt;
    end
  end

  // Hold accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        high_r[a] <= high_nxt[a];
        low_r[a]  <= low_nxt[a];
        sum_r[a]  <= sum_nxt[a];
      end
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    close_r |-> !job_full)
    else $error("closed window pushed into a full queue");

  a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    close_r |=> (count_r == '0) && !close_r)
    else $error("window not cleared after close");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    close_r |-> (count_r != '0) && (LW'(count_r) <= LW'(MAX_WINDOW)))
    else $error("closed window with bad sample count");

endmodule

/* hdl/gsd_back.sv */
`timescale 1ns / 1ps

module gsd_back #(
  parameter int SW = 32,
  parameter int CW = 13
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  output logic                     job_pop,
  input  gsd_pkg::gsd_flags_t      job_flags,
  input  logic signed [SW-1:0]     job_sum [gsd_pkg::NUM_AXES],
  input  logic [CW-1:0]            job_count,
  output logic                     out_empty,
  input  logic                     out_pop,
  output gsd_pkg::gsd_out_t        out_item
);

  import gsd_pkg::*;

  localparam int SCW = $clog2(SW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  state_t                    state_r;
  gsd_flags_t                flags_r;
  logic [NUM_AXES-1:0]       neg_r;
  logic [CW-1:0]             div_r;
  logic [CW-1:0]             rem_r [NUM_AXES];
  logic [SW-1:0]             quo_r [NUM_AXES];
  logic [SCW-1:0]            step_r;
  logic                      out_valid_r;
  gsd_out_t                  out_r;

  logic [CW-1:0]             rem_nxt [NUM_AXES];
  logic [SW-1:0]             quo_nxt [NUM_AXES];
  logic [SW-1:0]             mag     [NUM_AXES];
  logic signed [RATE_W-1:0]  bias    [NUM_AXES];
  gsd_out_t                  res;
  logic                      hand_over;

  assign job_pop   = (state_r == ST_IDLE) & job_valid;
  assign out_empty = ~out_valid_r;
  assign out_item  = out_r;

  // Load the result register once it is free or being popped
  assign hand_over = (state_r == ST_HOLD) & (~out_valid_r | out_pop);

  // Take the magnitude of each sum
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      mag[a] = job_sum[a][SW-1] ? $unsigned(-job_sum[a]) : $unsigned(job_sum[a]);
    end
  end

  // One restoring division step per lane
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      logic [CW:0] shifted;
      logic [CW:0] diff;
      logic        ge;
      shifted    = {rem_r[a], quo_r[a][SW-1]};
      diff       = shifted - {1'b0, div_r};
      ge         = (shifted >= {1'b0, div_r});
      rem_nxt[a] = ge ? diff[CW-1:0] : shifted[CW-1:0];
      quo_nxt[a] = {quo_r[a][SW-2:0], ge};
    end
  end

  // Negate the mean and saturate; zero bias without valid offsets
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!flags_r.offsets_valid) begin
        bias[a] = '0;
      end else if (neg_r[a]) begin
        bias[a] = (quo_r[a] > SW'(RATE_MAX)) ? RATE_MAX : quo_r[a][RATE_W-1:0];
      end else begin
        bias[a] = RATE_W'(0) - quo_r[a][RATE_W-1:0];
      end
    end
  end

  assign res.is_quiet      = flags_r.is_quiet;
  assign res.offsets_valid = flags_r.offsets_valid;
  assign res.bias_x        = bias[0];
  assign res.bias_y        = bias[1];
  assign res.bias_z        = bias[2];

  // Sequence load, divide and hand-over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (hand_over) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            flags_r <= job_flags;
            div_r   <= job_count;
            step_r  <= SCW'(SW - 1);
            for (int a = 0; a < NUM_AXES; a++) begin
              neg_r[a] <= job_sum[a][SW-1];
              rem_r[a] <= '0;
              quo_r[a] <= mag[a];
            end
            state_r <= job_flags.offsets_valid ? ST_DIVIDE : ST_HOLD;
          end
        end
        ST_DIVIDE: begin
          for (int a = 0; a < NUM_AXES; a++) begin
            rem_r[a] <= rem_nxt[a];
            quo_r[a] <= quo_nxt[a];
          end
          if (step_r == '0) begin
            state_r <= ST_HOLD;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        ST_HOLD: begin
          if (hand_over) begin
            out_r   <= res;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |-> (div_r != '0))
    else $error("division by zero sample count");

  a_bias_zero_without_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.offsets_valid)
      |-> (out_r.bias_x == '0) && (out_r.bias_y == '0) && (out_r.bias_z == '0))
    else $error("bias reported without valid offsets");

  a_offsets_need_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.is_quiet || !out_r.offsets_valid))
    else $error("offsets flagged on a noisy window");

endmodule

/* hdl/gyro_stillness_detector_top.sv */
`timescale 1ns / 1ps

// Gyro stillness detector. Each item is one three-axis gyro sample in signed
// fixed point; a window of window_length samples (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW) produces one result item telling whether
// every axis span stayed under span_threshold plus 2.0/4.0/5.0 deg/s, and,
// with calibration on and a quiet window, the negated window mean per axis
// as a bias offset. Samples are taken while no closed window is being
// handed on and the job queue has room; the sample that closes a window
// stalls the input while the window is classified and queued. The queued
// window then goes through a bit-serial divider with one lane per axis,
// after a load step and before a hand-over step; the division is skipped
// when no offsets are produced. A two-entry job queue sits between the
// sample side and the divider, so samples keep flowing while a division
// runs; with one-sample windows the divider sets the sustained rate.

module gyro_stillness_detector_top #(
  parameter int MAX_WINDOW = 4096,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  gsd_pkg::gsd_in_t                  in_item,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output gsd_pkg::gsd_out_t                 out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import gsd_pkg::*;

  localparam int CW       = $clog2(MAX_WINDOW + 1);
  localparam int SW       = RATE_W + $clog2(MAX_WINDOW);
  localparam int FLAGS_W  = $bits(gsd_flags_t);
  localparam int JW       = FLAGS_W + NUM_AXES * SW + CW;
  localparam int Q_DEPTH  = 2;

  logic [CFG_LEN_W-1:0]  window_length_r;
  logic [CFG_THR_W-1:0]  span_threshold_r;
  logic                  calibrate_enable_r;
  gsd_cfg_t              cfg;

  logic                  front_push;
  gsd_flags_t            front_flags;
  logic signed [SW-1:0]  front_sum [NUM_AXES];
  logic [CW-1:0]         front_count;

  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [JW-1:0]         q_din;
  logic [JW-1:0]         q_dout;
  gsd_flags_t            q_flags;
  logic signed [SW-1:0]  q_sum [NUM_AXES];
  logic [CW-1:0]         q_count;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r    <= WINDOW_LENGTH_RST;
      span_threshold_r   <= SPAN_THRESHOLD_RST;
      calibrate_enable_r <= CALIBRATE_ENABLE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:    window_length_r    <= cfg_data[CFG_LEN_W-1:0];
        CFG_SPAN_THRESHOLD:   span_threshold_r   <= cfg_data[CFG_THR_W-1:0];
        CFG_CALIBRATE_ENABLE: calibrate_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.window_length    = window_length_r;
  assign cfg.span_threshold   = span_threshold_r;
  assign cfg.calibrate_enable = calibrate_enable_r;

  gsd_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .FRAC_BITS  (FRAC_BITS),
    .SW         (SW),
    .CW         (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_push    (in_push),
    .in_item    (in_item),
    .in_full    (in_full),
    .job_push   (front_push),
    .job_full   (q_full),
    .job_flags  (front_flags),
    .job_sum    (front_sum),
    .job_count  (front_count)
  );

  // Pack a closed window for the queue
  assign q_din = {front_flags, front_sum[2], front_sum[1], front_sum[0], front_count};
  assign {q_flags, q_sum[2], q_sum[1], q_sum[0], q_count} = q_dout;

  gsd_job_queue #(
    .WIDTH (JW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  gsd_back #(
    .SW (SW),
    .CW (CW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (~q_empty),
    .job_pop    (q_pop),
    .job_flags  (q_flags),
    .job_sum    (q_sum),
    .job_count  (q_count),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule
